/* design/rdwr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdwr_pkg
// Shared types and constants for the random draw block.
// ----------------------------------------------------------------------------
package rdwr_pkg;

    typedef struct packed {
        logic [63:0] state_seed;
        logic [63:0] increment_seed;
    } in_t;

    typedef struct packed {
        logic [2:0] status;
        logic       is_extra;
        logic [2:0] slot;
        logic [7:0] drawn_value;
        logic       last;
    } out_t;

    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_BAD_MAIN_CNT  = 3'd1;
    localparam logic [2:0] ST_BAD_MAIN_RNG  = 3'd2;
    localparam logic [2:0] ST_FEW_MAIN      = 3'd3;
    localparam logic [2:0] ST_BAD_EXTRA_RNG = 3'd4;
    localparam logic [2:0] ST_FEW_EXTRA     = 3'd5;
    localparam logic [2:0] ST_POOL_BIG      = 3'd6;

    localparam logic [2:0] CFG_NUM_MAIN  = 3'd0;
    localparam logic [2:0] CFG_MAIN_LO   = 3'd1;
    localparam logic [2:0] CFG_MAIN_HI   = 3'd2;
    localparam logic [2:0] CFG_NUM_EXTRA = 3'd3;
    localparam logic [2:0] CFG_EXTRA_LO  = 3'd4;
    localparam logic [2:0] CFG_EXTRA_HI  = 3'd5;

    localparam logic [63:0] PCG_MULT = 64'd6364136223846793005;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_FILL_INIT_X,
        OP_FILL,
        OP_MUL0,
        OP_MUL1,
        OP_MUL2,
        OP_DIV,
        OP_RD_I,
        OP_RD_J,
        OP_WR_I,
        OP_WR_J,
        OP_EM_INIT,
        OP_EM_RD,
        OP_EM_LOAD,
        OP_ERR_LOAD
    } dp_op_t;

    typedef struct packed {
        logic [2:0] cfg_status;
        logic       fill_last;
        logic       i_zero;
        logic       div_done;
        logic       emit_last;
        logic       phase_extra;
        logic       has_extra;
        logic       out_free;
    } dp_stat_t;

endpackage

/* design/rdwr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdwr_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
module rdwr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata <= mem[addr];
        end
    end

endmodule

/* design/rdwr_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdwr_datapath
// Settings, checks, PCG32 generator, serial modulo, pool and result register.
// ----------------------------------------------------------------------------
module rdwr_datapath #(
    parameter int POOL_DEPTH = 128,
    parameter int MAX_MAIN   = 7,
    parameter int MAX_EXTRA  = 3
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  rdwr_pkg::dp_op_t   op,
    output rdwr_pkg::dp_stat_t stat,
    input  rdwr_pkg::in_t      s_data,
    input  logic               cfg_valid,
    input  logic [2:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    output logic               m_valid,
    input  logic               m_ready,
    output rdwr_pkg::out_t     m_data
);

    localparam int AW = $clog2(POOL_DEPTH);

    logic [2:0] num_main_reg;
    logic [7:0] main_lo_reg, main_hi_reg;
    logic [1:0] num_extra_reg;
    logic [7:0] extra_lo_reg, extra_hi_reg;

    logic [63:0] gen_state_reg, gen_inc_reg, prod_reg;
    logic [31:0] div_x_reg;
    logic [8:0]  rem_reg;
    logic [5:0]  div_cnt_reg;
    logic [7:0]  i_reg, j_reg, k_reg, data_i_reg;
    logic        phase_reg;
    logic        out_valid_reg;
    rdwr_pkg::out_t out_reg;

    logic [8:0]  msize, esize;
    logic [2:0]  chk;
    logic [7:0]  lo, span;
    logic [2:0]  cnt_sel;
    logic [31:0] mul_a, mul_b, xs, rnd;
    logic [63:0] pp;
    logic [9:0]  rem_sh;
    logic [8:0]  div_n;
    logic        ram_we, ram_re;
    logic [7:0]  ram_idx, ram_wdata, ram_rdata;
    logic        out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_main_reg  <= 3'd6;
            main_lo_reg   <= 8'd1;
            main_hi_reg   <= 8'd49;
            num_extra_reg <= 2'd0;
            extra_lo_reg  <= 8'd1;
            extra_hi_reg  <= 8'd10;
        end else if (cfg_valid) begin
            case (cfg_index)
                rdwr_pkg::CFG_NUM_MAIN:  num_main_reg  <= cfg_data[2:0];
                rdwr_pkg::CFG_MAIN_LO:   main_lo_reg   <= cfg_data;
                rdwr_pkg::CFG_MAIN_HI:   main_hi_reg   <= cfg_data;
                rdwr_pkg::CFG_NUM_EXTRA: num_extra_reg <= cfg_data[1:0];
                rdwr_pkg::CFG_EXTRA_LO:  extra_lo_reg  <= cfg_data;
                rdwr_pkg::CFG_EXTRA_HI:  extra_hi_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign msize = {1'b0, main_hi_reg} - {1'b0, main_lo_reg} + 9'd1;
    assign esize = {1'b0, extra_hi_reg} - {1'b0, extra_lo_reg} + 9'd1;

    always_comb begin
        if (num_main_reg == 3'd0 || num_main_reg > 3'(MAX_MAIN)) begin
            chk = rdwr_pkg::ST_BAD_MAIN_CNT;
        end else if (main_lo_reg == 8'd0 || main_hi_reg == 8'd0
                     || main_lo_reg > main_hi_reg) begin
            chk = rdwr_pkg::ST_BAD_MAIN_RNG;
        end else if (msize < {6'd0, num_main_reg}) begin
            chk = rdwr_pkg::ST_FEW_MAIN;
        end else if ({1'b0, num_extra_reg} > 3'(MAX_EXTRA)) begin
            chk = rdwr_pkg::ST_BAD_EXTRA_RNG;
        end else if (num_extra_reg != 2'd0 && extra_lo_reg > extra_hi_reg) begin
            chk = rdwr_pkg::ST_BAD_EXTRA_RNG;
        end else if (num_extra_reg != 2'd0 && esize < {7'd0, num_extra_reg}) begin
            chk = rdwr_pkg::ST_FEW_EXTRA;
        end else if (msize > 9'(POOL_DEPTH)
                     || (num_extra_reg != 2'd0 && esize > 9'(POOL_DEPTH))) begin
            chk = rdwr_pkg::ST_POOL_BIG;
        end else begin
            chk = rdwr_pkg::ST_OK;
        end
    end

    // PCG32 output of the old state, rotate via doubled word
    assign xs  = 32'(((gen_state_reg >> 18) ^ gen_state_reg) >> 27);
    assign rnd = 32'({xs, xs} >> gen_state_reg[63:59]);

    always_comb begin
        case (op)
            rdwr_pkg::OP_MUL1: begin
                mul_a = gen_state_reg[31:0];
                mul_b = rdwr_pkg::PCG_MULT[63:32];
            end
            rdwr_pkg::OP_MUL2: begin
                mul_a = gen_state_reg[63:32];
                mul_b = rdwr_pkg::PCG_MULT[31:0];
            end
            default: begin
                mul_a = gen_state_reg[31:0];
                mul_b = rdwr_pkg::PCG_MULT[31:0];
            end
        endcase
    end
    assign pp = mul_a * mul_b;

    assign div_n  = {1'b0, i_reg} + 9'd1;
    assign rem_sh = {rem_reg, div_x_reg[31]};

    assign lo      = phase_reg ? extra_lo_reg : main_lo_reg;
    assign span    = phase_reg ? (extra_hi_reg - extra_lo_reg)
                               : (main_hi_reg - main_lo_reg);
    assign cnt_sel = phase_reg ? {1'b0, num_extra_reg} : num_main_reg;
    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_idx   = k_reg;
        ram_wdata = lo + k_reg;
        case (op)
            rdwr_pkg::OP_FILL:  ram_we = 1'b1;
            rdwr_pkg::OP_RD_I: begin
                ram_re  = 1'b1;
                ram_idx = i_reg;
            end
            rdwr_pkg::OP_RD_J: begin
                ram_re  = 1'b1;
                ram_idx = j_reg;
            end
            rdwr_pkg::OP_WR_I: begin
                ram_we    = 1'b1;
                ram_idx   = i_reg;
                ram_wdata = ram_rdata;
            end
            rdwr_pkg::OP_WR_J: begin
                ram_we    = 1'b1;
                ram_idx   = j_reg;
                ram_wdata = data_i_reg;
            end
            rdwr_pkg::OP_EM_RD: ram_re = 1'b1;
            default: ;
        endcase
    end

    rdwr_ram #(
        .WIDTH (8),
        .DEPTH (POOL_DEPTH)
    ) u_pool (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_idx[AW-1:0]),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_state_reg <= '0;
            gen_inc_reg   <= '0;
            div_cnt_reg   <= '0;
            i_reg         <= '0;
            k_reg         <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (op == rdwr_pkg::OP_EM_LOAD || op == rdwr_pkg::OP_ERR_LOAD) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (op)
                rdwr_pkg::OP_LOAD: begin
                    gen_state_reg <= s_data.state_seed;
                    gen_inc_reg   <= {s_data.increment_seed[62:0], 1'b1};
                    phase_reg     <= 1'b0;
                    k_reg         <= '0;
                    i_reg         <= main_hi_reg - main_lo_reg;
                end
                rdwr_pkg::OP_FILL_INIT_X: begin
                    phase_reg <= 1'b1;
                    k_reg     <= '0;
                    i_reg     <= extra_hi_reg - extra_lo_reg;
                end
                rdwr_pkg::OP_FILL: k_reg <= k_reg + 8'd1;
                rdwr_pkg::OP_MUL2: begin
                    gen_state_reg <= prod_reg + {pp[31:0], 32'd0} + gen_inc_reg;
                    div_cnt_reg   <= 6'd32;
                end
                rdwr_pkg::OP_DIV: div_cnt_reg <= div_cnt_reg - 6'd1;
                rdwr_pkg::OP_WR_J: i_reg <= i_reg - 8'd1;
                rdwr_pkg::OP_EM_INIT: k_reg <= '0;
                rdwr_pkg::OP_EM_LOAD: k_reg <= k_reg + 8'd1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (op)
            rdwr_pkg::OP_MUL0: begin
                prod_reg  <= pp;
                div_x_reg <= rnd;
            end
            rdwr_pkg::OP_MUL1: prod_reg <= prod_reg + {pp[31:0], 32'd0};
            rdwr_pkg::OP_MUL2: rem_reg <= '0;
            rdwr_pkg::OP_DIV: begin
                div_x_reg <= {div_x_reg[30:0], 1'b0};
                if (rem_sh >= {1'b0, div_n}) begin
                    rem_reg <= 9'(rem_sh - {1'b0, div_n});
                end else begin
                    rem_reg <= rem_sh[8:0];
                end
            end
            rdwr_pkg::OP_RD_I: j_reg <= rem_reg[7:0];
            rdwr_pkg::OP_RD_J: data_i_reg <= ram_rdata;
            rdwr_pkg::OP_EM_LOAD: begin
                out_reg.status      <= rdwr_pkg::ST_OK;
                out_reg.is_extra    <= phase_reg;
                out_reg.slot        <= k_reg[2:0];
                out_reg.drawn_value <= ram_rdata;
                out_reg.last        <= (k_reg[2:0] == cnt_sel - 3'd1)
                                       && (phase_reg || num_extra_reg == 2'd0);
            end
            rdwr_pkg::OP_ERR_LOAD: begin
                out_reg.status      <= chk;
                out_reg.is_extra    <= 1'b0;
                out_reg.slot        <= '0;
                out_reg.drawn_value <= '0;
                out_reg.last        <= 1'b1;
            end
            default: ;
        endcase
    end

    assign stat.cfg_status  = chk;
    assign stat.fill_last   = (k_reg == span);
    assign stat.i_zero      = (i_reg == 8'd0);
    assign stat.div_done    = (div_cnt_reg == 6'd0);
    assign stat.emit_last   = (k_reg[2:0] == cnt_sel - 3'd1);
    assign stat.phase_extra = phase_reg;
    assign stat.has_extra   = (num_extra_reg != 2'd0);
    assign stat.out_free    = out_free;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_div_only_counting: assert property (@(posedge aclk) disable iff (!aresetn)
        op == rdwr_pkg::OP_DIV |-> div_cnt_reg != 6'd0)
        else $error("modulo step with no bits left");
    a_rem_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == rdwr_pkg::OP_DIV && div_cnt_reg == 6'd1) |=> rem_reg < div_n)
        else $error("swap index out of range");
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == rdwr_pkg::OP_EM_LOAD || op == rdwr_pkg::OP_ERR_LOAD) |-> out_free)
        else $error("result register overwritten");
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        op == rdwr_pkg::OP_EM_LOAD |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

/* design/rdwr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdwr_ctrl
// Sequencer for check, fill, shuffle and result phases.
// ----------------------------------------------------------------------------
module rdwr_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rdwr_pkg::dp_stat_t stat,
    output rdwr_pkg::dp_op_t   op
);

    typedef enum logic [3:0] {
        S_IDLE, S_ERR, S_INIT_X, S_FILL, S_SH_CHK, S_MUL0, S_MUL1, S_MUL2,
        S_DIV, S_RD_I, S_RD_J, S_WR_I, S_WR_J, S_EM_INIT, S_EM_RD, S_EM_LD
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        op         = rdwr_pkg::OP_NONE;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (stat.cfg_status == rdwr_pkg::ST_OK) begin
                        op         = rdwr_pkg::OP_LOAD;
                        state_next = S_FILL;
                    end else begin
                        state_next = S_ERR;
                    end
                end
            end
            S_ERR: begin
                if (stat.out_free) begin
                    op         = rdwr_pkg::OP_ERR_LOAD;
                    state_next = S_IDLE;
                end
            end
            S_INIT_X: begin
                op         = rdwr_pkg::OP_FILL_INIT_X;
                state_next = S_FILL;
            end
            S_FILL: begin
                op = rdwr_pkg::OP_FILL;
                if (stat.fill_last) begin
                    state_next = S_SH_CHK;
                end
            end
            S_SH_CHK: state_next = stat.i_zero ? S_EM_INIT : S_MUL0;
            S_MUL0: begin
                op         = rdwr_pkg::OP_MUL0;
                state_next = S_MUL1;
            end
            S_MUL1: begin
                op         = rdwr_pkg::OP_MUL1;
                state_next = S_MUL2;
            end
            S_MUL2: begin
                op         = rdwr_pkg::OP_MUL2;
                state_next = S_DIV;
            end
            S_DIV: begin
                if (stat.div_done) begin
                    state_next = S_RD_I;
                end else begin
                    op = rdwr_pkg::OP_DIV;
                end
            end
            S_RD_I: begin
                op         = rdwr_pkg::OP_RD_I;
                state_next = S_RD_J;
            end
            S_RD_J: begin
                op         = rdwr_pkg::OP_RD_J;
                state_next = S_WR_I;
            end
            S_WR_I: begin
                op         = rdwr_pkg::OP_WR_I;
                state_next = S_WR_J;
            end
            S_WR_J: begin
                op         = rdwr_pkg::OP_WR_J;
                state_next = S_SH_CHK;
            end
            S_EM_INIT: begin
                op         = rdwr_pkg::OP_EM_INIT;
                state_next = S_EM_RD;
            end
            S_EM_RD: begin
                op         = rdwr_pkg::OP_EM_RD;
                state_next = S_EM_LD;
            end
            S_EM_LD: begin
                if (stat.out_free) begin
                    op = rdwr_pkg::OP_EM_LOAD;
                    if (!stat.emit_last) begin
                        state_next = S_EM_RD;
                    end else if (!stat.phase_extra && stat.has_extra) begin
                        state_next = S_INIT_X;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    a_err_only_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        op == rdwr_pkg::OP_ERR_LOAD |-> stat.cfg_status != rdwr_pkg::ST_OK)
        else $error("error result with good settings");
    a_shuffle_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        op == rdwr_pkg::OP_MUL0 |-> !stat.i_zero)
        else $error("generator stepped at shuffle end");
    a_swap_order: assert property (@(posedge aclk) disable iff (!aresetn)
        op == rdwr_pkg::OP_RD_I |=> op == rdwr_pkg::OP_RD_J ##1 op == rdwr_pkg::OP_WR_I)
        else $error("swap sequence broken");

endmodule

/* design/random_draw_without_replacement.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_draw_without_replacement
// PCG32-driven Fisher-Yates draw of main and extra numbers.
//
//   channel  direction  handshake            beat
//   s_       in         s_valid / s_ready    two 64-bit seeds
//   m_       out        m_valid / m_ready    one drawn number or error
//   cfg_     in         cfg_valid/cfg_ready  register index and data
//
// A pool of N numbers is filled with N writes; each swap then takes three
// 32x32 partial products, a 32-step serial modulo and four pool accesses.
// One request runs at a time; s_ready is high only between requests.
// Reset is synchronous, active low; the pool needs no clearing pass.
// A stalled m_ready holds the sequencer before each result load.
// ----------------------------------------------------------------------------
module random_draw_without_replacement #(
    parameter int POOL_DEPTH = 128,
    parameter int MAX_MAIN   = 7,
    parameter int MAX_EXTRA  = 3
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  rdwr_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output rdwr_pkg::out_t m_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [2:0]     cfg_index,
    input  logic [7:0]     cfg_data
);

    rdwr_pkg::dp_op_t   op;
    rdwr_pkg::dp_stat_t stat;

    assign cfg_ready = 1'b1;

    rdwr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .op      (op)
    );

    rdwr_datapath #(
        .POOL_DEPTH (POOL_DEPTH),
        .MAX_MAIN   (MAX_MAIN),
        .MAX_EXTRA  (MAX_EXTRA)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op        (op),
        .stat      (stat),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

/* tb/draw_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// draw_checker
// Watches the seed, result and register channels of the random draw block.
// Every seed beat goes through a local PCG32 / Fisher-Yates model; its drawn
// numbers, or an error beat, are queued. Each result beat is compared with
// the oldest queued beat. Mismatches are counted and passed to the top.
// ----------------------------------------------------------------------------
module draw_checker (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic           s_ready,
    input  rdwr_pkg::in_t  s_data,
    input  logic           m_valid,
    input  logic           m_ready,
    input  rdwr_pkg::out_t m_data,
    input  logic           cfg_valid,
    input  logic           cfg_ready,
    input  logic [2:0]     cfg_index,
    input  logic [7:0]     cfg_data,
    output int             fail_count,
    output int             pending_draws
);

    logic [2:0]  num_main;
    logic [7:0]  main_lo;
    logic [7:0]  main_hi;
    logic [1:0]  num_extra;
    logic [7:0]  extra_lo;
    logic [7:0]  extra_hi;
    logic [63:0] gen_state;
    logic [63:0] gen_inc;
    logic [7:0]  pool [256];
    rdwr_pkg::out_t expected_draws [$];

    function automatic logic [31:0] pcg_step();
        logic [63:0] old;
        logic [31:0] xs;
        logic [4:0]  rot;
        old = gen_state;
        gen_state = old * rdwr_pkg::PCG_MULT + gen_inc;
        xs = 32'(((old >> 18) ^ old) >> 27);
        rot = old[63:59];
        return (xs >> rot) | (xs << ((32 - rot) & 31));
    endfunction

    function automatic void shuffle_pool(int lo, int size);
        int j;
        logic [7:0] t;
        for (int i = 0; i < size; i++) pool[i] = 8'(lo + i);
        for (int i = size - 1; i > 0; i--) begin
            j = int'(pcg_step() % 32'(i + 1));
            t = pool[i];
            pool[i] = pool[j];
            pool[j] = t;
        end
    endfunction

    function automatic logic [2:0] settings_status();
        int msize;
        int esize;
        if (num_main == 0 || num_main > 7) return rdwr_pkg::ST_BAD_MAIN_CNT;
        if (main_lo == 0 || main_hi == 0 || main_lo > main_hi)
            return rdwr_pkg::ST_BAD_MAIN_RNG;
        msize = int'(main_hi) - int'(main_lo) + 1;
        if (msize < num_main) return rdwr_pkg::ST_FEW_MAIN;
        esize = 0;
        if (num_extra > 0) begin
            if (extra_lo > extra_hi) return rdwr_pkg::ST_BAD_EXTRA_RNG;
            esize = int'(extra_hi) - int'(extra_lo) + 1;
            if (esize < num_extra) return rdwr_pkg::ST_FEW_EXTRA;
        end
        if (msize > 128 || esize > 128) return rdwr_pkg::ST_POOL_BIG;
        return rdwr_pkg::ST_OK;
    endfunction

    function automatic void predict_draw(rdwr_pkg::in_t seeds);
        rdwr_pkg::out_t r;
        logic [2:0] st;
        st = settings_status();
        if (st != rdwr_pkg::ST_OK) begin
            r = '{status: st, is_extra: 1'b0, slot: 3'd0, drawn_value: 8'd0, last: 1'b1};
            expected_draws.push_back(r);
            return;
        end
        gen_state = seeds.state_seed;
        gen_inc = {seeds.increment_seed[62:0], 1'b1};
        shuffle_pool(main_lo, int'(main_hi) - int'(main_lo) + 1);
        for (int i = 0; i < num_main; i++) begin
            r = '{status: rdwr_pkg::ST_OK, is_extra: 1'b0, slot: 3'(i),
                  drawn_value: pool[i], last: (i + 1 == num_main) && num_extra == 0};
            expected_draws.push_back(r);
        end
        if (num_extra > 0) begin
            shuffle_pool(extra_lo, int'(extra_hi) - int'(extra_lo) + 1);
            for (int i = 0; i < num_extra; i++) begin
                r = '{status: rdwr_pkg::ST_OK, is_extra: 1'b1, slot: 3'(i),
                      drawn_value: pool[i], last: i + 1 == num_extra};
                expected_draws.push_back(r);
            end
        end
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t: draw mismatch: %s", $time, what);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge aclk) begin
        rdwr_pkg::out_t e;
        if (!aresetn) begin
            num_main <= 3'd6;
            main_lo <= 8'd1;
            main_hi <= 8'd49;
            num_extra <= 2'd0;
            extra_lo <= 8'd1;
            extra_hi <= 8'd10;
            gen_state = '0;
            gen_inc = '0;
            expected_draws.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    rdwr_pkg::CFG_NUM_MAIN:  num_main <= cfg_data[2:0];
                    rdwr_pkg::CFG_MAIN_LO:   main_lo <= cfg_data;
                    rdwr_pkg::CFG_MAIN_HI:   main_hi <= cfg_data;
                    rdwr_pkg::CFG_NUM_EXTRA: num_extra <= cfg_data[1:0];
                    rdwr_pkg::CFG_EXTRA_LO:  extra_lo <= cfg_data;
                    rdwr_pkg::CFG_EXTRA_HI:  extra_hi <= cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) predict_draw(s_data);
            if (m_valid && m_ready) begin
                if (expected_draws.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat %p", m_data));
                end else begin
                    e = expected_draws.pop_front();
                    if (m_data.status != e.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  m_data.status, e.status));
                    if (m_data.is_extra != e.is_extra)
                        report_mismatch($sformatf("is_extra %0d, want %0d",
                                                  m_data.is_extra, e.is_extra));
                    if (m_data.slot != e.slot)
                        report_mismatch($sformatf("slot %0d, want %0d",
                                                  m_data.slot, e.slot));
                    if (m_data.drawn_value != e.drawn_value)
                        report_mismatch($sformatf("value %0d, want %0d",
                                                  m_data.drawn_value, e.drawn_value));
                    if (m_data.last != e.last)
                        report_mismatch($sformatf("last %0d, want %0d",
                                                  m_data.last, e.last));
                end
            end
        end
        pending_draws = expected_draws.size();
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the random draw block: runs several register
// settings (defaults, extremes, every error status), sends directed and
// random seed pairs with random gaps and output stalls, one long stall
// included, and leaves checking to draw_checker.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT = 6000000;

    logic           aclk;
    logic           aresetn;
    logic           s_valid;
    logic           s_ready;
    rdwr_pkg::in_t  s_data;
    logic           m_valid;
    logic           m_ready;
    rdwr_pkg::out_t m_data;
    logic           cfg_valid;
    logic           cfg_ready;
    logic [2:0]     cfg_index;
    logic [7:0]     cfg_data;
    int             fail_count;
    int             pending_draws;
    int             cycle_count;
    bit             calm;
    bit             hold_off;
    int             seeds_sent;

    random_draw_without_replacement dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    draw_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_draws(pending_draws)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // result side: random stalls, with calm and long hold-off stretches
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off) m_ready <= 1'b0;
            else if (calm) m_ready <= 1'b1;
            else m_ready <= ($urandom_range(99) >= 37);
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [7:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    task automatic set_regs(int mc, int mn, int mx, int ec, int en, int ex);
        write_reg(rdwr_pkg::CFG_NUM_MAIN, 8'(mc));
        write_reg(rdwr_pkg::CFG_MAIN_LO, 8'(mn));
        write_reg(rdwr_pkg::CFG_MAIN_HI, 8'(mx));
        write_reg(rdwr_pkg::CFG_NUM_EXTRA, 8'(ec));
        write_reg(rdwr_pkg::CFG_EXTRA_LO, 8'(en));
        write_reg(rdwr_pkg::CFG_EXTRA_HI, 8'(ex));
        cfg_valid <= 1'b0;
    endtask

    // more: another beat follows at once, so valid is left to the next call
    task automatic send_seeds(logic [63:0] st, logic [63:0] inc, bit more = 1'b0);
        if (!calm) begin
            while ($urandom_range(99) < 37) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_data <= '{state_seed: st, increment_seed: inc};
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        seeds_sent++;
        @(negedge aclk);
        if (!more) s_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_draws != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic random_seeds(int n);
        for (int k = 0; k < n; k++) send_seeds(rand64(), rand64(), k < n - 1);
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        calm = 1'b0;
        hold_off = 1'b0;
        seeds_sent = 0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        // defaults, seed extremes
        send_seeds('0, '0, 1'b1);
        send_seeds('1, '1, 1'b1);
        send_seeds(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b1);
        send_seeds(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001);
        drain();

        // error statuses, in check order
        set_regs(0, 1, 49, 0, 1, 10);  send_seeds(rand64(), rand64()); drain();
        set_regs(3, 0, 49, 0, 1, 10);  send_seeds(rand64(), rand64()); drain();
        set_regs(3, 10, 0, 0, 1, 10);  send_seeds(rand64(), rand64()); drain();
        set_regs(3, 20, 10, 0, 1, 10); send_seeds(rand64(), rand64()); drain();
        set_regs(7, 5, 10, 0, 1, 10);  send_seeds(rand64(), rand64()); drain();
        set_regs(3, 1, 10, 2, 9, 3);   send_seeds(rand64(), rand64()); drain();
        set_regs(3, 1, 10, 3, 4, 5);   send_seeds(rand64(), rand64()); drain();
        set_regs(3, 1, 255, 0, 1, 10); send_seeds(rand64(), rand64()); drain();
        set_regs(3, 1, 10, 1, 0, 255); send_seeds(rand64(), rand64()); drain();

        // extremes: pool of one, full depth, top of range
        set_regs(1, 255, 255, 1, 0, 0);     send_seeds(rand64(), rand64()); drain();
        set_regs(7, 1, 128, 3, 0, 127);     send_seeds(rand64(), rand64()); drain();
        set_regs(7, 249, 255, 3, 253, 255); send_seeds(rand64(), rand64()); drain();

        // long hold-off while the sender keeps offering
        set_regs(7, 1, 12, 3, 1, 6);
        hold_off = 1'b1;
        fork
            random_seeds(4);
            begin
                repeat (3000) @(negedge aclk);
                hold_off = 1'b0;
            end
        join
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            calm = (ph == 2);
            if (ph == 5) begin
                set_regs(5, 1, 49, 2, 1, 12);
            end else begin
                set_regs($urandom_range(7, 1), $urandom_range(20, 1),
                         $urandom_range(40, 20), $urandom_range(3),
                         $urandom_range(255), 255);
            end
            random_seeds(15);
            drain();
        end
        calm = 1'b0;

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
